@@ rtl/psd_pkg.sv @@
// shared types, constants and helpers of the partitioned state digest
`default_nettype none

package psd_pkg;

	// configuration port geometry and register indexes
	localparam int REG_W     = 24;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_LENGTH      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_REGION_END  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_REGION_END = 2'd2;

	// region ends are moved past the length prefix
	localparam int BOUND_PAD = 4;
	// images below this length report all zeros
	localparam int SHORT_LEN = 4;

	// hash constants
	localparam logic [63:0] MUL_A   = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] MUL_B   = 64'hD6E8_FEB8_6659_FD93;
	localparam logic [63:0] SEED_R0 = 64'h6E65_735F_6370_7500;
	localparam logic [63:0] SEED_R1 = 64'h6E65_735F_7070_7500;
	localparam logic [63:0] SEED_R2 = 64'h6E65_735F_6170_7500;
	localparam logic [63:0] SEED_W  = 64'h6E65_735F_6D73_7400;
	localparam int MIX_SHIFT  = 29;
	localparam int FOLD_SHIFT = 32;

	// hash operations carried from the front to the back
	typedef enum logic [1:0] {
		OP_SEED = 2'd0,
		OP_MIX  = 2'd1,
		OP_FIN  = 2'd2
	} op_t;

	// which hash an operation works on
	typedef enum logic [1:0] {
		TGT_R0 = 2'd0,
		TGT_R1 = 2'd1,
		TGT_R2 = 2'd2,
		TGT_W  = 2'd3
	} tgt_t;

	// one queued hash command
	typedef struct packed {
		op_t         op;
		tgt_t        tgt;
		logic        short_image;
		logic [63:0] word;
	} cmd_t;

	// per-hash seed value
	function automatic logic [63:0] seed_of(input tgt_t tgt);
		logic [63:0] s;
		unique case (tgt)
			TGT_R0: s = SEED_R0;
			TGT_R1: s = SEED_R1;
			TGT_R2: s = SEED_R2;
			TGT_W:  s = SEED_W;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

@@ rtl/partitioned_state_digest.sv @@
// top level of the partitioned state digest
`default_nettype none

// Streams an image in one byte per transaction on push/full and keeps four
// 64-bit multiply/xorshift hashes: one over the whole image and one for each
// of three consecutive regions whose ends come from the configuration
// registers (each end plus four, clamped to the image length). After the
// last byte of an image one digest transaction appears on the result side
// (empty/pop); images shorter than four bytes report all zeros. A
// configuration write restarts the image in progress. The front takes a byte
// without stalling unless it starts or ends an image, completes a hash word or
// crosses a region end; each seed, word mix or finalize then goes through a
// four-entry command queue to the back, which runs it on one shared 32x32
// multiplier (three partial products per 64-bit multiply). The first byte
// of an image adds two seeds, each region end adds a finalize and a seed
// (plus a tail mix when the region stops mid-word), and the image end adds
// the finalizes and seeds of the regions still open and the whole-image
// finalize (plus its tail mix). There is no clearing pass after reset.
module partitioned_state_digest #(
	parameter int LENGTH_BITS = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [7:0]                    data_byte,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [31:0]                        first_region_digest,
	output logic [31:0]                        second_region_digest,
	output logic [31:0]                        third_region_digest,
	output logic [31:0]                        whole_digest,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [psd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [psd_pkg::REG_W-1:0]     cfg_data
);
	import psd_pkg::*;

	cmd_t        cmd, q_head;
	logic        cmd_valid, cmd_full, q_empty, q_pop;
	logic        mul_start, mul_done;
	logic [63:0] mul_a, mul_b, mul_product;

	// byte intake and command issue
	psd_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_full  (cmd_full)
	);

	// decoupling queue
	psd_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_valid),
		.din    (cmd),
		.full   (cmd_full),
		.pop    (q_pop),
		.dout   (q_head),
		.empty  (q_empty)
	);

	// hash execution
	psd_back u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.q_empty              (q_empty),
		.q_head               (q_head),
		.q_pop                (q_pop),
		.mul_start            (mul_start),
		.mul_a                (mul_a),
		.mul_b                (mul_b),
		.mul_done             (mul_done),
		.mul_product          (mul_product),
		.empty                (empty),
		.pop                  (pop),
		.first_region_digest  (first_region_digest),
		.second_region_digest (second_region_digest),
		.third_region_digest  (third_region_digest),
		.whole_digest         (whole_digest)
	);

	// shared multiplier
	psd_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_product)
	);

endmodule

`default_nettype wire

@@ rtl/psd_mul.sv @@
// 64 by 64 bit low-half multiplier built on one shared 32 by 32 multiplier
`default_nettype none

module psd_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [63:0]      product
);
	import psd_pkg::*;

	typedef enum logic [4:0] {
		M_IDLE = 5'b00001,
		M_LL   = 5'b00010,
		M_LH   = 5'b00100,
		M_HL   = 5'b01000,
		M_ACC  = 5'b10000
	} mstate_t;

	mstate_t     state_q, state_d;
	logic        done_q;
	logic [63:0] a_q, b_q, pp_q, acc_q;
	logic [31:0] mx, my;
	logic [63:0] mprod;

	// partial product operand selection
	assign mx    = (state_q == M_HL) ? a_q[63:32] : a_q[31:0];
	assign my    = (state_q == M_LH) ? b_q[63:32] : b_q[31:0];
	assign mprod = mx * my;

	// step sequence: low*low, low*high, high*low
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			M_IDLE: if (start) state_d = M_LL;
			M_LL:   state_d = M_LH;
			M_LH:   state_d = M_HL;
			M_HL:   state_d = M_ACC;
			M_ACC:  state_d = M_IDLE;
			default: state_d = M_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == M_ACC);
		end
	end

	// operands, product register and accumulator
	always_ff @(posedge clk) begin
		if (state_q == M_IDLE && start) begin
			a_q <= a;
			b_q <= b;
		end
		pp_q <= mprod;
		if (state_q == M_LH) begin
			acc_q <= pp_q;
		end else if (state_q == M_HL || state_q == M_ACC) begin
			acc_q[63:32] <= acc_q[63:32] + pp_q[31:0];
		end
	end

	assign done    = done_q;
	assign product = acc_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (state_q == M_IDLE))
		else $error("multiply started while busy");

endmodule

`default_nettype wire

@@ rtl/psd_cmd_fifo.sv @@
// four-entry command queue between the front and the back
`default_nettype none

module psd_cmd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire psd_pkg::cmd_t din,
	output logic               full,
	input  wire logic          pop,
	output psd_pkg::cmd_t      dout,
	output logic               empty
);
	import psd_pkg::*;

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;
	logic          push_ok, pop_ok;

	assign full    = (count_q == (PW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop_ok) rd_ptr_q <= rd_ptr_q + PW'(1);
			unique case ({push_ok, pop_ok})
				2'b10:   count_q <= count_q + (PW+1)'(1);
				2'b01:   count_q <= count_q - (PW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push_ok) mem_q[wr_ptr_q] <= din;
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command popped from empty queue");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok |=> !empty)
		else $error("queue empty after a write");

endmodule

`default_nettype wire

@@ rtl/psd_front.sv @@
// byte intake, region tracking, word assembly and hash command issue
`default_nettype none

module psd_front #(
	parameter int LENGTH_BITS = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [7:0]                    data_byte,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [psd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [psd_pkg::REG_W-1:0]     cfg_data,
	output logic                               cmd_valid,
	output psd_pkg::cmd_t                      cmd,
	input  wire logic                          cmd_full
);
	import psd_pkg::*;

	localparam int LB = LENGTH_BITS;
	localparam int BW = ((LB > REG_W) ? LB : REG_W) + 1;

	typedef enum logic [10:0] {
		F_IDLE   = 11'b000_0000_0001,
		F_SEED_W = 11'b000_0000_0010,
		F_SEED_R = 11'b000_0000_0100,
		F_CHECK  = 11'b000_0000_1000,
		F_MIX_W  = 11'b000_0001_0000,
		F_MIX_R  = 11'b000_0010_0000,
		F_TAIL_R = 11'b000_0100_0000,
		F_FIN_R  = 11'b000_1000_0000,
		F_END    = 11'b001_0000_0000,
		F_TAIL_W = 11'b010_0000_0000,
		F_FIN_W  = 11'b100_0000_0000
	} fstate_t;

	// configuration registers
	logic [REG_W-1:0] image_length_q, first_end_q, second_end_q;
	logic             cfg_hit, settle_q;

	// derived bounds
	logic [BW-1:0] len_ext, tot_c, sum1, sum2, e1_c, e2_c;
	logic [LB-1:0] tot_q, e1_q, e2_q, n0_q, n1_q, n2_q;
	logic          short_q;

	// sequencer and position state
	fstate_t       state_q, state_d;
	logic [LB-1:0] p_q;
	logic [1:0]    r_q;
	logic [2:0]    roff_q;
	logic          ending_q, mixr_pend_q;
	logic [7:0]    byte_q, cur_byte;
	logic [63:0]   wword_q, rword_q;

	logic          accept, adv_need, last, mixw, mixr;
	logic          do_merge, p_inc, p_clr, r_inc, set_end, pushed;
	logic [LB-1:0] cur_end, cur_len;
	tgt_t          cur_tgt;
	fstate_t       after_merge, adv_state;

	function automatic logic [63:0] merge_byte(input logic [63:0] word,
		input logic [2:0] off, input logic [7:0] b);
		logic [63:0] w;
		w = (off == 3'd0) ? 64'd0 : word;
		w[{off, 3'b000} +: 8] = b;
		return w;
	endfunction

	function automatic tgt_t region_tgt(input logic [1:0] r);
		tgt_t t;
		if (r == 2'd0) t = TGT_R0;
		else if (r == 2'd1) t = TGT_R1;
		else t = TGT_R2;
		return t;
	endfunction

	// configuration write decode
	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == CFG_IMAGE_LENGTH ||
		cfg_index == CFG_FIRST_REGION_END || cfg_index == CFG_SECOND_REGION_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_length_q <= REG_W'(1);
			first_end_q    <= '0;
			second_end_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_IMAGE_LENGTH:      image_length_q <= cfg_data;
				CFG_FIRST_REGION_END:  first_end_q    <= cfg_data;
				CFG_SECOND_REGION_END: second_end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// region bounds: clamp ends to the image length
	always_comb begin
		len_ext = BW'(image_length_q) & BW'({LB{1'b1}});
		tot_c   = (len_ext == '0) ? BW'(1) : len_ext;
		sum2    = BW'(second_end_q) + BW'(BOUND_PAD);
		e2_c    = (sum2 > tot_c) ? tot_c : sum2;
		sum1    = BW'(first_end_q) + BW'(BOUND_PAD);
		e1_c    = (sum1 > e2_c) ? e2_c : sum1;
	end

	always_ff @(posedge clk) begin
		tot_q   <= tot_c[LB-1:0];
		e1_q    <= e1_c[LB-1:0];
		e2_q    <= e2_c[LB-1:0];
		n0_q    <= e1_c[LB-1:0];
		n1_q    <= LB'(e2_c - e1_c);
		n2_q    <= LB'(tot_c - e2_c);
		short_q <= (tot_c < BW'(SHORT_LEN));
	end

	// current region view
	always_comb begin
		cur_tgt = region_tgt(r_q);
		if (r_q == 2'd0) begin
			cur_end = e1_q;
			cur_len = n0_q;
		end else if (r_q == 2'd1) begin
			cur_end = e2_q;
			cur_len = n1_q;
		end else begin
			cur_end = tot_q;
			cur_len = n2_q;
		end
	end

	assign full      = (state_q != F_IDLE) || settle_q;
	assign accept    = push && !full;
	assign cur_byte  = (state_q == F_IDLE) ? data_byte : byte_q;
	assign adv_need  = (r_q != 2'd2) && (p_q >= cur_end);
	assign last      = (p_q == tot_q - LB'(1));
	assign mixw      = (p_q[2:0] == 3'd7);
	assign mixr      = (roff_q == 3'd7);
	assign pushed    = cmd_valid && !cmd_full;
	assign adv_state = (roff_q != 3'd0) ? F_TAIL_R : F_FIN_R;

	always_comb begin
		if (mixw) after_merge = F_MIX_W;
		else if (mixr) after_merge = F_MIX_R;
		else if (last) after_merge = F_END;
		else after_merge = F_IDLE;
	end

	// command sequencer
	always_comb begin
		state_d   = state_q;
		cmd_valid = 1'b0;
		cmd       = '{op: OP_MIX, tgt: TGT_W, short_image: 1'b0, word: 64'd0};
		do_merge  = 1'b0;
		p_inc     = 1'b0;
		p_clr     = 1'b0;
		r_inc     = 1'b0;
		set_end   = 1'b0;
		unique case (state_q)
			F_IDLE, F_CHECK: begin
				if (state_q == F_CHECK || (accept && p_q != '0)) begin
					if (adv_need) begin
						state_d = adv_state;
					end else begin
						do_merge = 1'b1;
						state_d  = after_merge;
						p_inc    = (after_merge == F_IDLE);
					end
				end else if (accept) begin
					state_d = F_SEED_W;
				end
			end
			F_SEED_W: begin
				cmd_valid = 1'b1;
				cmd       = '{op: OP_SEED, tgt: TGT_W, short_image: 1'b0,
					word: 64'(tot_q)};
				if (pushed) state_d = F_SEED_R;
			end
			F_SEED_R: begin
				cmd_valid = 1'b1;
				cmd       = '{op: OP_SEED, tgt: cur_tgt, short_image: 1'b0,
					word: 64'(cur_len)};
				if (pushed) state_d = ending_q ? F_END : F_CHECK;
			end
			F_MIX_W: begin
				cmd_valid = 1'b1;
				cmd.word  = wword_q;
				if (pushed) begin
					if (mixr_pend_q) state_d = F_MIX_R;
					else if (last) state_d = F_END;
					else begin
						state_d = F_IDLE;
						p_inc   = 1'b1;
					end
				end
			end
			F_MIX_R, F_TAIL_R: begin
				cmd_valid = 1'b1;
				cmd.tgt   = cur_tgt;
				cmd.word  = rword_q;
				if (pushed) begin
					if (state_q == F_TAIL_R) state_d = F_FIN_R;
					else if (last) state_d = F_END;
					else begin
						state_d = F_IDLE;
						p_inc   = 1'b1;
					end
				end
			end
			F_FIN_R: begin
				cmd_valid = 1'b1;
				cmd.op    = OP_FIN;
				cmd.tgt   = cur_tgt;
				if (pushed) begin
					if (r_q != 2'd2) begin
						r_inc   = 1'b1;
						state_d = F_SEED_R;
					end else begin
						state_d = (p_q[2:0] != 3'd7) ? F_TAIL_W : F_FIN_W;
					end
				end
			end
			F_END: begin
				set_end = 1'b1;
				state_d = adv_state;
			end
			F_TAIL_W: begin
				cmd_valid = 1'b1;
				cmd.word  = wword_q;
				if (pushed) state_d = F_FIN_W;
			end
			F_FIN_W: begin
				cmd_valid        = 1'b1;
				cmd.op           = OP_FIN;
				cmd.short_image  = short_q;
				if (pushed) begin
					state_d = F_IDLE;
					p_clr   = 1'b1;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	// control state; a configuration write restarts the image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			settle_q    <= 1'b1;
			p_q         <= '0;
			r_q         <= '0;
			roff_q      <= '0;
			ending_q    <= 1'b0;
			mixr_pend_q <= 1'b0;
		end else begin
			settle_q <= cfg_hit;
			if (cfg_hit) begin
				state_q  <= F_IDLE;
				p_q      <= '0;
				ending_q <= 1'b0;
			end else begin
				state_q <= state_d;
				if (p_inc) p_q <= p_q + LB'(1);
				if (p_clr) begin
					p_q      <= '0;
					ending_q <= 1'b0;
				end
				if (accept && p_q == '0) begin
					r_q      <= '0;
					roff_q   <= '0;
					ending_q <= 1'b0;
				end
				if (do_merge) begin
					roff_q      <= roff_q + 3'd1;
					mixr_pend_q <= mixr;
				end
				if (r_inc) begin
					r_q    <= r_q + 2'd1;
					roff_q <= '0;
				end
				if (set_end) ending_q <= 1'b1;
			end
		end
	end

	// byte latch and word assembly
	always_ff @(posedge clk) begin
		if (accept) byte_q <= data_byte;
		if (do_merge) begin
			wword_q <= merge_byte(wword_q, p_q[2:0], cur_byte);
			rword_q <= merge_byte(rword_q, roff_q, cur_byte);
		end
	end

endmodule

`default_nettype wire

@@ rtl/psd_back.sv @@
// hash state, command execution and result register
`default_nettype none

module psd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_empty,
	input  wire psd_pkg::cmd_t q_head,
	output logic               q_pop,
	output logic               mul_start,
	output logic [63:0]        mul_a,
	output logic [63:0]        mul_b,
	input  wire logic          mul_done,
	input  wire logic [63:0]   mul_product,
	output logic               empty,
	input  wire logic          pop,
	output logic [31:0]        first_region_digest,
	output logic [31:0]        second_region_digest,
	output logic [31:0]        third_region_digest,
	output logic [31:0]        whole_digest
);
	import psd_pkg::*;

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_WAIT = 3'b010,
		B_OUT  = 3'b100
	} bstate_t;

	bstate_t     state_q, state_d;
	cmd_t        cmd_q;
	logic        out_valid_q, out_load, short_q;
	logic [63:0] whole_h_q, region_h_q, hsel, seeded, mixed, fin;
	logic [31:0] held_first_q, held_second_q, third_q, whole_q, digest;
	logic [31:0] out_first_q, out_second_q, out_third_q, out_whole_q;

	// multiplier operand for the command at the queue head
	always_comb begin
		hsel = (q_head.tgt == TGT_W) ? whole_h_q : region_h_q;
		unique case (q_head.op)
			OP_MIX:  mul_a = hsel ^ q_head.word;
			OP_FIN:  mul_a = hsel ^ (hsel >> FOLD_SHIFT);
			default: mul_a = q_head.word;
		endcase
		mul_b = (q_head.op == OP_FIN) ? MUL_B : MUL_A;
	end

	assign mul_start = (state_q == B_IDLE) && !q_empty;
	assign q_pop     = mul_start;

	// post-multiply results
	always_comb begin
		seeded = seed_of(cmd_q.tgt) ^ mul_product;
		mixed  = mul_product ^ (mul_product >> MIX_SHIFT);
		fin    = mul_product ^ (mul_product >> FOLD_SHIFT);
		digest = fin[31:0] ^ fin[63:32];
	end

	assign out_load = (state_q == B_OUT) && (!out_valid_q || pop);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (!q_empty) state_d = B_WAIT;
			B_WAIT: begin
				if (mul_done) begin
					state_d = (cmd_q.op == OP_FIN && cmd_q.tgt == TGT_W) ? B_OUT : B_IDLE;
				end
			end
			B_OUT: if (out_load) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	// hash registers and held digests
	always_ff @(posedge clk) begin
		if (q_pop) cmd_q <= q_head;
		if (state_q == B_WAIT && mul_done) begin
			unique case (cmd_q.op)
				OP_SEED: begin
					if (cmd_q.tgt == TGT_W) whole_h_q <= seeded;
					else region_h_q <= seeded;
				end
				OP_MIX: begin
					if (cmd_q.tgt == TGT_W) whole_h_q <= mixed;
					else region_h_q <= mixed;
				end
				OP_FIN: begin
					unique case (cmd_q.tgt)
						TGT_R0: held_first_q  <= digest;
						TGT_R1: held_second_q <= digest;
						TGT_R2: third_q       <= digest;
						TGT_W: begin
							whole_q <= digest;
							short_q <= cmd_q.short_image;
						end
					endcase
				end
				default: ;
			endcase
		end
		if (out_load) begin
			out_first_q  <= short_q ? 32'd0 : held_first_q;
			out_second_q <= short_q ? 32'd0 : held_second_q;
			out_third_q  <= short_q ? 32'd0 : third_q;
			out_whole_q  <= short_q ? 32'd0 : whole_q;
		end
	end

	assign empty                = !out_valid_q;
	assign first_region_digest  = out_first_q;
	assign second_region_digest = out_second_q;
	assign third_region_digest  = out_third_q;
	assign whole_digest         = out_whole_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == B_WAIT))
		else $error("multiply finished with no command waiting");

endmodule

`default_nettype wire
